// ===== hdl/circular_orbit_position_generator_core_macros.svh =====
// Assertion macros for the checker file of the orbit generator.
// Depends on nothing; included by the checker module.
`ifndef CIRCULAR_ORBIT_POSITION_GENERATOR_CORE_MACROS_SVH
`define CIRCULAR_ORBIT_POSITION_GENERATOR_CORE_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define COPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a signal is never unknown outside reset.
`define COPG_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);

`endif

// ===== hdl/copg_pkg.sv =====
// Shared types, constants and tables of the circular orbit position generator.
// Depends on nothing; used by all modules of the block but the checker.
`default_nettype none
package copg_pkg;

    localparam int OBJECT_COUNT = 2;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [30:0] LAT_MIN = -31'sd900000000;
    localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
    localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
    localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [34:0] CORDIC_X0 = 35'sd652032874;
    localparam logic [24:0] LON_SCALE_RESET = 25'd65536;

    localparam logic [1:0] REG_HOME_LAT = 2'd0;
    localparam logic [1:0] REG_HOME_LON = 2'd1;
    localparam logic [1:0] REG_LON_SCALE = 2'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Command handed from the front end to the query engine.
    typedef struct packed {
        logic       valid_idx;
        logic       obj;
        logic [31:0] phase;
    } query_cmd_t;

    typedef struct packed {
        logic        valid_res;
        logic [30:0] latitude;
        logic [31:0] longitude;
        logic [13:0] altitude_dm;
        logic [15:0] heading_cdeg;
        logic [13:0] speed_cms;
    } result_t;

    function automatic logic [31:0] phase_step(input logic obj);
        phase_step = obj ? (32'd0 - 32'd14240943) : 32'd32042122;
    endfunction

    function automatic logic [31:0] phase_reset(input logic obj);
        phase_reset = obj ? HALF_TURN : 32'd0;
    endfunction

    function automatic logic [31:0] head_offset(input logic obj);
        head_offset = obj ? (32'd0 - QUARTER_TURN) : QUARTER_TURN;
    endfunction

    function automatic logic signed [15:0] lat_radius(input logic obj);
        lat_radius = obj ? 16'sd10780 : 16'sd7186;
    endfunction

    function automatic logic [13:0] alt_value(input logic obj);
        alt_value = obj ? 14'd500 : 14'd300;
    endfunction

    function automatic logic [13:0] spd_value(input logic obj);
        spd_value = obj ? 14'd1000 : 14'd1500;
    endfunction

    function automatic logic [29:0] atan_value(input logic [STEP_W-1:0] i);
        case (i)
            4'd0:    atan_value = 30'd536870912;
            4'd1:    atan_value = 30'd316933406;
            4'd2:    atan_value = 30'd167458907;
            4'd3:    atan_value = 30'd85004756;
            4'd4:    atan_value = 30'd42667331;
            4'd5:    atan_value = 30'd21354465;
            4'd6:    atan_value = 30'd10679838;
            4'd7:    atan_value = 30'd5340245;
            4'd8:    atan_value = 30'd2670163;
            4'd9:    atan_value = 30'd1335087;
            4'd10:   atan_value = 30'd667544;
            4'd11:   atan_value = 30'd333772;
            4'd12:   atan_value = 30'd166886;
            4'd13:   atan_value = 30'd83443;
            4'd14:   atan_value = 30'd41722;
            default: atan_value = 30'd20861;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/copg_front.sv =====
// Front end: accepts input items, keeps the orbit phases and advances them on
// a tick, and turns a query into a command for the queue. Uses copg_pkg.
`default_nettype none
module copg_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 kind,
    input  wire logic [1:0]           drone_index,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output copg_pkg::query_cmd_t      cmd
);

    logic [31:0] phase_reg [copg_pkg::OBJECT_COUNT];
    logic        is_query;

    assign is_query = (kind == copg_pkg::KIND_QUERY);
    // A tick needs no queue slot; a query waits for one.
    assign in_ready = !is_query || cmd_ready;
    assign cmd_valid = in_valid && is_query;

    always_comb
    begin
        cmd.valid_idx = (drone_index < 2'(copg_pkg::OBJECT_COUNT));
        cmd.obj = drone_index[0];
        cmd.phase = phase_reg[drone_index[0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < copg_pkg::OBJECT_COUNT; i++)
                phase_reg[i] <= copg_pkg::phase_reset(1'(i));
        end
        else if (in_valid && in_ready && !is_query)
        begin
            for (int i = 0; i < copg_pkg::OBJECT_COUNT; i++)
                phase_reg[i] <= phase_reg[i] + copg_pkg::phase_step(1'(i));
        end
    end

endmodule
`default_nettype wire

// ===== hdl/copg_queue.sv =====
// Two-entry command queue between the front end and the query engine.
// Uses copg_pkg for the command type.
`default_nettype none
module copg_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire copg_pkg::query_cmd_t wr_data,
    output logic                      rd_valid,
    input  wire logic                 rd_ready,
    output copg_pkg::query_cmd_t      rd_data
);

    copg_pkg::query_cmd_t mem_reg [copg_pkg::QUEUE_DEPTH];
    logic                 wptr_reg, wptr_next;
    logic                 rptr_reg, rptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_wr, do_rd;

    assign wr_ready = (count_reg != 2'(copg_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data = mem_reg[rptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_wr;
        rptr_next = rptr_reg ^ do_rd;
        count_next = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== hdl/copg_engine.sv =====
// Back end: one CORDIC rotation step per cycle, then scaling, saturation and
// heading conversion over the registered steps MUL1, MUL2, MUL3, SUM and SAT. Uses copg_pkg.
`default_nettype none
module copg_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire copg_pkg::query_cmd_t cmd,
    input  wire logic signed [30:0]   home_lat,
    input  wire logic signed [31:0]   home_lon,
    input  wire logic [24:0]          lon_scale,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output copg_pkg::result_t         res
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROT, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_SAT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [copg_pkg::STEP_W-1:0] step_reg;
    logic                 obj_reg, flip_reg, vidx_reg;
    logic [31:0]          phase_reg;
    logic signed [34:0]   x_reg, y_reg;
    logic signed [32:0]   z_reg;
    logic signed [15:0]   sin_reg, cos_reg;
    logic signed [31:0]   lat_off_p_reg;   // R*sin
    logic signed [31:0]   rc_reg;          // R*cos
    logic signed [57:0]   lon_lo_reg;      // R*cos*scale[15:0]
    logic signed [57:0]   lon_hi_reg;      // R*cos*scale[24:16]
    logic [47:0]          hd_prod_reg;
    logic signed [32:0]   lat_sum_reg;
    logic signed [33:0]   lon_sum_reg;
    copg_pkg::result_t    res_reg;

    logic signed [34:0]   dx, dy, x_n, y_n;
    logic signed [32:0]   z_n, atan_s;
    logic [31:0]          p_fold, head;
    logic                 flip;
    logic signed [34:0]   xf, yf;
    logic signed [15:0]   s_q, c_q;
    logic signed [57:0]   lon_full;
    logic signed [31:0]   lat_off;
    logic signed [31:0]   lon_off;
    logic [16:0]          hd;

    function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
        logic signed [35:0] r;
        r = (36'(v) + 36'sd16384) >>> 15;
        if (r > 36'sd32767)
            to_q15 = 16'sd32767;
        else if (r < -36'sd32767)
            to_q15 = -16'sd32767;
        else
            to_q15 = 16'(r);
    endfunction

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res = res_reg;

    always_comb
    begin
        flip = ((cmd.phase + copg_pkg::QUARTER_TURN) & copg_pkg::HALF_TURN) != 32'd0;
        p_fold = flip ? (cmd.phase ^ copg_pkg::HALF_TURN) : cmd.phase;
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        atan_s = 33'(copg_pkg::atan_value(step_reg));
        if (!z_reg[32])
        begin
            x_n = x_reg - dx;
            y_n = y_reg + dy;
            z_n = z_reg - atan_s;
        end
        else
        begin
            x_n = x_reg + dx;
            y_n = y_reg - dy;
            z_n = z_reg + atan_s;
        end
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        s_q = to_q15(yf);
        c_q = to_q15(xf);
        head = phase_reg + copg_pkg::head_offset(obj_reg);
        lon_full = lon_lo_reg + (lon_hi_reg <<< 16) + 58'sd1073741824;
        lon_off = 32'(lon_full >>> 31);
        lat_off = (lat_off_p_reg + 32'sd16384) >>> 15;
        hd = 17'((hd_prod_reg + 48'h0_8000_0000) >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        obj_reg <= cmd.obj;
                        vidx_reg <= cmd.valid_idx;
                        phase_reg <= cmd.phase;
                        flip_reg <= flip;
                        x_reg <= copg_pkg::CORDIC_X0;
                        y_reg <= '0;
                        z_reg <= 33'(signed'(p_fold));
                        step_reg <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    x_reg <= x_n;
                    y_reg <= y_n;
                    z_reg <= z_n;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == copg_pkg::STEP_W'(copg_pkg::CORDIC_STEPS - 1))
                        state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    sin_reg <= s_q;
                    cos_reg <= c_q;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    lat_off_p_reg <= 32'(copg_pkg::lat_radius(obj_reg)) * 32'(sin_reg);
                    rc_reg <= 32'(copg_pkg::lat_radius(obj_reg)) * 32'(cos_reg);
                    hd_prod_reg <= 48'(head) * 48'd36000;
                    state_reg <= ST_MUL3;
                end
                ST_MUL3:
                begin
                    lon_lo_reg <= 58'(rc_reg) * 58'(signed'({1'b0, lon_scale[15:0]}));
                    lon_hi_reg <= 58'(rc_reg) * 58'(signed'({1'b0, lon_scale[24:16]}));
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    lat_sum_reg <= 33'(home_lat) + 33'(lat_off);
                    lon_sum_reg <= 34'(home_lon) + 34'(lon_off);
                    state_reg <= ST_SAT;
                    if (vidx_reg)
                    begin
                        res_reg.valid_res <= 1'b1;
                        res_reg.altitude_dm <= copg_pkg::alt_value(obj_reg);
                        res_reg.speed_cms <= copg_pkg::spd_value(obj_reg);
                        res_reg.heading_cdeg <= (hd >= 17'd36000) ? 16'd0 : 16'(hd);
                    end
                    else
                    begin
                        res_reg.valid_res <= 1'b0;
                        res_reg.altitude_dm <= '0;
                        res_reg.speed_cms <= '0;
                        res_reg.heading_cdeg <= '0;
                    end
                end
                ST_SAT:
                begin
                    if (!vidx_reg)
                    begin
                        res_reg.latitude <= '0;
                        res_reg.longitude <= '0;
                    end
                    else
                    begin
                        if (lat_sum_reg > 33'(copg_pkg::LAT_MAX))
                            res_reg.latitude <= copg_pkg::LAT_MAX;
                        else if (lat_sum_reg < 33'(copg_pkg::LAT_MIN))
                            res_reg.latitude <= copg_pkg::LAT_MIN;
                        else
                            res_reg.latitude <= 31'(lat_sum_reg);
                        if (lon_sum_reg > 34'(copg_pkg::LON_MAX))
                            res_reg.longitude <= copg_pkg::LON_MAX;
                        else if (lon_sum_reg < 34'(copg_pkg::LON_MIN))
                            res_reg.longitude <= copg_pkg::LON_MIN;
                        else
                            res_reg.longitude <= 32'(lon_sum_reg);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/circular_orbit_position_generator_core.sv =====
// Top level of the circular orbit position generator: register file, front
// end, command queue and query engine. Uses copg_pkg and the copg_* modules.
//
// Two orbiting objects keep a binary-angle phase each. A tick transfer (kind 0)
// advances both phases and gives no result. A query transfer (kind 1) passes
// through the queue, the shared CORDIC rotation step, then multiply, sum and
// saturation steps before its result is offered. The engine takes one query at
// a time; a two-entry queue lets the input accept up to two more queries and
// any number of ticks meanwhile. A query sees the phase held when it was
// accepted. Configuration writes are taken at any time.
`default_nettype none
module circular_orbit_position_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] drone_index
    input  wire logic        s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [111:0]     m_axis_tdata,   // latitude, longitude, altitude_dm,
                                             // heading_cdeg, speed_cms
    output logic             m_axis_tuser,   // [0] valid_res
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic signed [30:0] home_lat_reg;
    logic signed [31:0] home_lon_reg;
    logic [24:0]        lon_scale_reg;
    logic               fq_valid, fq_ready, qe_valid, qe_ready;
    copg_pkg::query_cmd_t fq_cmd, qe_cmd;
    copg_pkg::result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_lat_reg <= '0;
            home_lon_reg <= '0;
            lon_scale_reg <= copg_pkg::LON_SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                copg_pkg::REG_HOME_LAT:  home_lat_reg <= cfg_data[30:0];
                copg_pkg::REG_HOME_LON:  home_lon_reg <= cfg_data;
                copg_pkg::REG_LON_SCALE: lon_scale_reg <= cfg_data[24:0];
                default: ;
            endcase
        end
    end

    copg_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .kind(s_axis_tuser), .drone_index(s_axis_tdata[1:0]),
        .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
    );

    copg_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
        .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_cmd)
    );

    copg_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(qe_valid), .cmd_ready(qe_ready), .cmd(qe_cmd),
        .home_lat(home_lat_reg), .home_lon(home_lon_reg), .lon_scale(lon_scale_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tuser = res.valid_res;
    assign m_axis_tdata = {5'd0, res.speed_cms, res.heading_cdeg, res.altitude_dm,
                           res.longitude, res.latitude};

endmodule
`default_nettype wire

// ===== hdl/copg_checker.sv =====
// Port-level checker for the orbit generator, bound to the top level.
// Uses the assertion macros header.
`default_nettype none
`include "circular_orbit_position_generator_core_macros.svh"
module copg_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);

    `COPG_ASSERT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `COPG_ASSERT(a_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 112'd0, "invalid index result not zero")
    `COPG_ASSERT(a_head, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[92:77] < 16'd36000, "heading out of range")
    `COPG_ASSERT(a_gap, clk, rst_n, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid, "results back to back")

endmodule

bind circular_orbit_position_generator_core copg_checker u_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

// ===== tb/circular_orbit_position_generator_core_tb.sv =====
// Testbench of the circular orbit position generator: drives tick and query
// transfers and register writes, and checks every result against a predictor.
// Depends on copg_pkg and on circular_orbit_position_generator_core.
`default_nettype none
module circular_orbit_position_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts orbit positions and holds the results still to come.
    class orbit_scoreboard;
        logic [31:0] phase_q[2];
        longint      lat_home, lon_home, scale_q16;
        copg_pkg::result_t pending_pos[$];
        int          errors;
        longint      atan_q30[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861};

        function void restart();
            phase_q[0] = 32'd0;
            phase_q[1] = 32'h8000_0000;
            lat_home = 0;
            lon_home = 0;
            scale_q16 = 65536;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == copg_pkg::REG_HOME_LAT)
                lat_home = longint'($signed(data[30:0]));
            else if (idx == copg_pkg::REG_HOME_LON)
                lon_home = longint'($signed(data));
            else if (idx == copg_pkg::REG_LON_SCALE)
                scale_q16 = longint'({39'd0, data[24:0]});
        endfunction

        function longint round_q15(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function copg_pkg::result_t position_of(logic [1:0] idx);
            copg_pkg::result_t r;
            longint      x, y, z, dx, dy, s, c, rad, lat, lon;
            logic [31:0] ph, p, h;
            logic [63:0] hd;
            bit          flip;
            logic        o;
            r = '0;
            if (idx >= 2) return r;
            o = idx[0];
            ph = phase_q[o];
            flip = ((ph + 32'h4000_0000) & 32'h8000_0000) != 0;
            p = flip ? (ph ^ 32'h8000_0000) : ph;
            z = longint'($signed(p));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_q30[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atan_q30[i];
                end
            end
            if (flip)
            begin
                x = -x; y = -y;
            end
            s = round_q15(y);
            c = round_q15(x);
            rad = o ? 10780 : 7186;
            lat = clip(lat_home + ((rad * s + 64'sd16384) >>> 15), -900000000, 900000000);
            lon = clip(lon_home + ((rad * c * scale_q16 + 64'sd1073741824) >>> 31),
                       -1800000000, 1800000000);
            h = ph + (o ? 32'hC000_0000 : 32'h4000_0000);
            hd = ({32'd0, h} * 64'd36000 + 64'h8000_0000) >> 32;
            if (hd >= 36000) hd = 0;
            r.valid_res = 1'b1;
            r.latitude = lat[30:0];
            r.longitude = lon[31:0];
            r.altitude_dm = o ? 14'd500 : 14'd300;
            r.heading_cdeg = hd[15:0];
            r.speed_cms = o ? 14'd1000 : 14'd1500;
            return r;
        endfunction

        function void note_input(logic kind, logic [1:0] idx);
            if (kind == copg_pkg::KIND_TICK)
            begin
                phase_q[0] += 32'd32042122;
                phase_q[1] -= 32'd14240943;
            end
            else
                pending_pos.push_back(position_of(idx));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [111:0] data, logic user);
            copg_pkg::result_t e;
            if (pending_pos.size() == 0)
            begin
                report_mismatch("unexpected result", {63'd0, user}, 64'd0);
                return;
            end
            e = pending_pos.pop_front();
            if (user != e.valid_res) report_mismatch("valid_res", user, e.valid_res);
            if (data[30:0] != e.latitude) report_mismatch("latitude", data[30:0], e.latitude);
            if (data[62:31] != e.longitude)
                report_mismatch("longitude", data[62:31], e.longitude);
            if (data[76:63] != e.altitude_dm)
                report_mismatch("altitude_dm", data[76:63], e.altitude_dm);
            if (data[92:77] != e.heading_cdeg)
                report_mismatch("heading_cdeg", data[92:77], e.heading_cdeg);
            if (data[106:93] != e.speed_cms)
                report_mismatch("speed_cms", data[106:93], e.speed_cms);
            if (data[111:107] != 5'd0) report_mismatch("pad bits", data[111:107], 0);
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    orbit_scoreboard sb = new();
    bit              no_stalls = 1'b0;

    circular_orbit_position_generator_core dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random unless a quiet stretch is running.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= no_stalls || ($urandom_range(99) >= 20);
        end
    end

    task send_item(logic kind, logic [1:0] idx);
        if (!no_stalls && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, idx};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(kind, idx);
    endtask

    task go_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pos.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sends count input items, mixing single queries with bursts of ticks.
    task random_items(int count);
        int n;
        int k;
        k = 0;
        while (k < count)
        begin
            if ($urandom_range(99) < 45)
            begin
                send_item(copg_pkg::KIND_QUERY, 2'($urandom_range(3)));
                k++;
            end
            else
            begin
                // Tick bursts sweep the phases through many angles.
                n = $urandom_range(20, 1);
                if (n > count - k)
                    n = count - k;
                repeat (n) send_item(copg_pkg::KIND_TICK, 2'($urandom_range(3)));
                k += n;
            end
        end
    endtask

    initial
    begin
        #2ms;
        $display("circular_orbit_position_generator_core test failed");
        $finish;
    end

    initial
    begin
        sb.restart();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every index at reset phases, ticks, then queries again.
        for (int i = 0; i < 4; i++) send_item(copg_pkg::KIND_QUERY, 2'(i));
        send_item(copg_pkg::KIND_TICK, 2'd3);
        send_item(copg_pkg::KIND_TICK, 2'd0);
        for (int i = 0; i < 4; i++) send_item(copg_pkg::KIND_QUERY, 2'(3 - i));
        go_idle();
        write_cfg(copg_pkg::REG_HOME_LAT, 32'd900000000);
        write_cfg(copg_pkg::REG_HOME_LON, 32'd1800000000);
        write_cfg(copg_pkg::REG_LON_SCALE, 32'h01FF_FFFF);
        write_cfg(2'd3, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) send_item(copg_pkg::KIND_QUERY, 2'(i));
        send_item(copg_pkg::KIND_TICK, 2'd1);
        send_item(copg_pkg::KIND_QUERY, 2'd0);
        send_item(copg_pkg::KIND_QUERY, 2'd1);
        go_idle();
        write_cfg(copg_pkg::REG_HOME_LAT, -32'sd900000000);
        write_cfg(copg_pkg::REG_HOME_LON, -32'sd1800000000);
        write_cfg(copg_pkg::REG_LON_SCALE, 32'd16777216);
        send_item(copg_pkg::KIND_QUERY, 2'd0);
        send_item(copg_pkg::KIND_QUERY, 2'd1);

        for (int phase_no = 0; phase_no < 5; phase_no++)
        begin
            go_idle();
            case (phase_no)
                0:
                begin
                    write_cfg(copg_pkg::REG_HOME_LAT, 32'd0);
                    write_cfg(copg_pkg::REG_HOME_LON, 32'd0);
                    write_cfg(copg_pkg::REG_LON_SCALE, 32'd65536);
                end
                1:
                begin
                    write_cfg(copg_pkg::REG_HOME_LAT,
                              32'($urandom_range(1800000000)) - 900000000);
                    write_cfg(copg_pkg::REG_HOME_LON, $urandom);
                    write_cfg(copg_pkg::REG_LON_SCALE,
                              32'($urandom_range(16777216, 65536)));
                end
                2:
                begin
                    // Out of range values still saturate.
                    write_cfg(copg_pkg::REG_HOME_LAT, $urandom);
                    write_cfg(copg_pkg::REG_HOME_LON, $urandom);
                    write_cfg(copg_pkg::REG_LON_SCALE, $urandom);
                    write_cfg(2'd3, $urandom);
                end
                3:
                begin
                    write_cfg(copg_pkg::REG_HOME_LAT, 32'd899999000);
                    write_cfg(copg_pkg::REG_HOME_LON, -32'sd1799999000);
                    write_cfg(copg_pkg::REG_LON_SCALE, 32'd16777216);
                end
                default:
                begin
                    write_cfg(copg_pkg::REG_HOME_LAT, 32'h0000_0000);
                    write_cfg(copg_pkg::REG_HOME_LON, 32'h0000_0000);
                    write_cfg(copg_pkg::REG_LON_SCALE, 32'h0000_0000);
                end
            endcase
            no_stalls = (phase_no == 3);
            random_items(86);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_pos.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("circular_orbit_position_generator_core test passed");
        else
            $display("circular_orbit_position_generator_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/copg_pkg.sv
hdl/copg_front.sv
hdl/copg_queue.sv
hdl/copg_engine.sv
hdl/circular_orbit_position_generator_core.sv
hdl/copg_checker.sv
tb/circular_orbit_position_generator_core_tb.sv
